@@ rtl/cmdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Command line classifier package
// Shared constants, event codes and the record type passed front to back.
// ----------------------------------------------------------------------------
package cmdc_pkg;

  // Longest kept line is LINE_CAPACITY-1 bytes.
  localparam int LINE_CAPACITY = 256;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);
  localparam int HEAD_DEPTH    = 9;

  localparam int LIMIT_W       = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic [7:0] BYTE_NEWLINE = 8'd10;
  localparam logic [7:0] BYTE_CR      = 8'd13;
  localparam logic [7:0] BYTE_ZERO    = 8'd0;

  localparam int EVT_W = 3;
  localparam logic [EVT_W-1:0] EVT_NONE      = 3'd0;
  localparam logic [EVT_W-1:0] EVT_STOP      = 3'd1;
  localparam logic [EVT_W-1:0] EVT_HEARTBEAT = 3'd2;
  localparam logic [EVT_W-1:0] EVT_NEXT      = 3'd3;
  localparam logic [EVT_W-1:0] EVT_PREV      = 3'd4;
  localparam logic [EVT_W-1:0] EVT_PLAYPAUSE = 3'd5;

  // One queued record: a finished line and/or a chunk boundary.
  typedef struct packed {
    logic             is_line;
    logic [EVT_W-1:0] code;
    logic             last;
  } evt_rec_t;

endpackage

@@ rtl/command_line_classifier_top.sv @@
// ----------------------------------------------------------------------------
// Command line classifier top level
// Turns a byte stream of newline-terminated commands into event codes.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                  Role
//   data      data_valid, data_ready, data_byte,       one stream byte in
//             chunk_last
//   event     event_valid, event_ready, event_code     one event code out
//   cfg       cfg_valid, cfg_ready, cfg_data           events-per-chunk limit
//
// One byte is taken every cycle while the record queue has room. The front
// end updates the line state and, on a newline, classifies the line in the
// same cycle it accepts the byte. A line end or chunk mark enters the
// four-entry record queue; the back end pops each record, applies the chunk
// limit and loads the output register. data_ready drops only when the queue
// is full, which happens only after the event channel has stalled. Reset is
// synchronous; there is no clearing pass. cfg_ready is always high.
//
module command_line_classifier_top import cmdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_ready,
  input  logic [7:0]         data_byte,
  input  logic               chunk_last,
  output logic               event_valid,
  input  logic               event_ready,
  output logic [EVT_W-1:0]   event_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic     accept;
  logic     push;
  evt_rec_t push_rec;
  logic     full;
  logic     pop;
  logic     head_valid;
  evt_rec_t head_rec;

  // The front end never waits on anything but space in the queue.
  assign data_ready = !full;
  assign accept     = data_valid && data_ready;
  assign cfg_ready  = 1'b1;

  cmdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .chunk_last (chunk_last),
    .push       (push),
    .rec        (push_rec)
  );

  cmdc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // The back end drains one record per cycle whenever the output register
  // is empty or being taken in the same cycle.
  cmdc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .head_valid  (head_valid),
    .head_rec    (head_rec),
    .pop         (pop),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_code  (event_code)
  );

endmodule

@@ rtl/cmdc_front.sv @@
// ----------------------------------------------------------------------------
// Command line classifier front end
// Assembles lines byte by byte and classifies each kept line on its newline.
// ----------------------------------------------------------------------------
module cmdc_front import cmdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       chunk_last,
  output logic       push,
  output evt_rec_t   rec
);

  logic [HEAD_DEPTH-1:0][7:0] head_bytes;
  logic [CNT_W-1:0]           line_count;
  logic [CNT_W-1:0]           text_length;
  logic [CNT_W-1:0]           trimmed_length;
  logic                       zero_seen;
  logic                       discard_mode;

  logic is_newline;
  logic kept_line;
  logic has_room;
  logic [EVT_W-1:0] code;

  assign is_newline = (data_byte == BYTE_NEWLINE);
  assign kept_line  = !discard_mode && is_newline;
  assign has_room   = (line_count < CNT_W'(LINE_CAPACITY - 1));

  // The head bytes read here were all written by the current line, since
  // trimmed_length never exceeds the bytes stored before the first zero.
  always_comb begin
    code = EVT_NONE;
    if (trimmed_length == CNT_W'(4) &&
        {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]} == "STOP") begin
      code = EVT_STOP;
    end else if (trimmed_length == CNT_W'(4) &&
        {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]} == "PING") begin
      code = EVT_HEARTBEAT;
    end else if (trimmed_length >= CNT_W'(5) &&
        {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3],
         head_bytes[4]} == "HELLO") begin
      code = EVT_HEARTBEAT;
    end else if (trimmed_length == CNT_W'(4) &&
        {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]} == "NEXT") begin
      code = EVT_NEXT;
    end else if (trimmed_length == CNT_W'(4) &&
        {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]} == "PREV") begin
      code = EVT_PREV;
    end else if (trimmed_length == CNT_W'(9) &&
        {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3], head_bytes[4],
         head_bytes[5], head_bytes[6], head_bytes[7], head_bytes[8]} == "PLAYPAUSE") begin
      code = EVT_PLAYPAUSE;
    end
  end

  assign push        = accept && (kept_line || chunk_last);
  assign rec.is_line = kept_line;
  assign rec.code    = code;
  assign rec.last    = chunk_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= '0;
      text_length    <= '0;
      trimmed_length <= '0;
      zero_seen      <= 1'b0;
      discard_mode   <= 1'b0;
    end else if (accept) begin
      if (discard_mode) begin
        if (is_newline) begin
          discard_mode <= 1'b0;
        end
      end else if (is_newline) begin
        line_count     <= '0;
        text_length    <= '0;
        trimmed_length <= '0;
        zero_seen      <= 1'b0;
      end else if (has_room) begin
        line_count <= line_count + CNT_W'(1);
        if (!zero_seen) begin
          if (data_byte == BYTE_ZERO) begin
            zero_seen <= 1'b1;
          end else begin
            text_length <= text_length + CNT_W'(1);
            if (data_byte != BYTE_CR) begin
              trimmed_length <= text_length + CNT_W'(1);
            end
          end
        end
      end else begin
        discard_mode   <= 1'b1;
        line_count     <= '0;
        text_length    <= '0;
        trimmed_length <= '0;
        zero_seen      <= 1'b0;
      end
    end
  end

  // Head storage: each entry is written only at its own line position.
  always_ff @(posedge clk) begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      if (accept && !discard_mode && !is_newline && has_room &&
          line_count == CNT_W'(i)) begin
        head_bytes[i] <= data_byte;
      end
    end
  end

endmodule

@@ rtl/cmdc_fifo.sv @@
// ----------------------------------------------------------------------------
// Command line classifier record queue
// Small register queue decoupling line assembly from event delivery.
// ----------------------------------------------------------------------------
module cmdc_fifo import cmdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  evt_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output evt_rec_t head_rec
);

  evt_rec_t             entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     fill;

  assign full       = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (fill != '0);
  assign head_rec   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("record queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("record queue read while empty");
`endif

endmodule

@@ rtl/cmdc_back.sv @@
// ----------------------------------------------------------------------------
// Command line classifier back end
// Applies the per-chunk event limit and holds the output register.
// ----------------------------------------------------------------------------
module cmdc_back import cmdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               head_valid,
  input  evt_rec_t           head_rec,
  output logic               pop,
  output logic               event_valid,
  input  logic               event_ready,
  output logic [EVT_W-1:0]   event_code
);

  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] chunk_events;
  logic               out_free;
  logic               emit;

  assign out_free = !event_valid || event_ready;
  assign pop      = head_valid && out_free;
  assign emit     = pop && head_rec.is_line && (chunk_events < limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= LIMIT_RESET;
      chunk_events <= '0;
      event_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      // The line is counted first, then a chunk boundary clears the count.
      if (pop) begin
        if (head_rec.last) begin
          chunk_events <= '0;
        end else if (emit) begin
          chunk_events <= chunk_events + LIMIT_W'(1);
        end
      end
      if (emit) begin
        event_valid <= 1'b1;
      end else if (event_ready) begin
        event_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_code <= head_rec.code;
    end
  end

`ifndef ASSERT_OFF
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (event_code <= EVT_PLAYPAUSE))
    else $error("event code out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head_rec.last) |=> (chunk_events == '0))
    else $error("chunk boundary did not clear the event count");
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> event_valid)
    else $error("emitted event not presented");
`endif

endmodule

@@ tb/sv/tb_command_line_classifier_top.sv @@
// ----------------------------------------------------------------------------
// Command line classifier testbench
// Drives byte streams of command lines into the classifier and checks every
// event code it returns against an in-bench model of the line assembler,
// under random sender gaps, receiver stalls and several event limits.
// ----------------------------------------------------------------------------
module tb_command_line_classifier_top;
  import cmdc_pkg::*;

  // The slowest correct run stays far below this: each byte may wait out a
  // sender gap and a receiver stall, plus one long hold-off and a few
  // overlong lines.
  localparam int CYCLE_LIMIT  = 400000;
  // Records that carry no event (chunk marks, dropped lines) may still sit in
  // the four-entry queue when the last expected event has arrived. This many
  // cycles lets them drain before the limit register is rewritten.
  localparam int DRAIN_CYCLES = 16;
  // Byte transactions the whole run aims for; random traffic fills up to it.
  localparam int TOTAL_ITEMS  = 1600;
  localparam int PRINT_CAP    = 100;
  localparam int HOLD_CYCLES  = 300;

  // Stall patterns of the event receiver.
  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PERIODIC
  } ready_mode_t;

  // Shapes of a random command line.
  typedef enum int {
    LINE_COMMAND,
    LINE_NEAR_MISS,
    LINE_GARBAGE,
    LINE_OVERLONG
  } line_kind_t;

  // Every input of the block starts at a known value.
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               data_valid  = 1'b0;
  logic [7:0]         data_byte   = 8'h00;
  logic               chunk_last  = 1'b0;
  logic               event_ready = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [LIMIT_W-1:0] cfg_data    = '0;
  logic               data_ready;
  logic               event_valid;
  logic [EVT_W-1:0]   event_code;
  logic               cfg_ready;

  command_line_classifier_top dut (
    .clk         (clk),
    .rst         (rst),
    .data_valid  (data_valid),
    .data_ready  (data_ready),
    .data_byte   (data_byte),
    .chunk_last  (chunk_last),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_code  (event_code),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Line assembler model. It is updated at the clock edge at which a byte
  // transaction completes and queues the event code that byte produces.
  // --------------------------------------------------------------------------
  logic [7:0]         line_head [HEAD_DEPTH];
  int                 line_len    = 0;
  int                 text_len    = 0;
  int                 trim_len    = 0;
  bit                 zero_in_line = 1'b0;
  bit                 dropping    = 1'b0;
  logic [LIMIT_W-1:0] chunk_count = '0;
  logic [LIMIT_W-1:0] event_limit = LIMIT_RESET;
  logic [EVT_W-1:0]   expected_events [$];

  int          mismatches    = 0;
  int          cycle_count   = 0;
  int          items_sent    = 0;
  int unsigned chunk_pct     = 0;
  bit          no_gaps       = 1'b0;
  int          burst_left    = 0;
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          mode_left     = 0;
  ready_mode_t ready_mode    = READY_ALWAYS;
  logic [EVT_W-1:0] want_code;
  logic [7:0]  line_body [$];

  // True when the stored head of the line starts with the given word. Only
  // positions the current line has written are ever compared, since every
  // caller checks the trimmed length first.
  function automatic bit head_is(input string word);
    for (int i = 0; i < word.len() && i < HEAD_DEPTH; i++) begin
      if (line_head[i] != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [EVT_W-1:0] line_code();
    if (trim_len == 4 && head_is("STOP")) return EVT_STOP;
    if (trim_len == 4 && head_is("PING")) return EVT_HEARTBEAT;
    if (trim_len >= 5 && head_is("HELLO")) return EVT_HEARTBEAT;
    if (trim_len == 4 && head_is("NEXT")) return EVT_NEXT;
    if (trim_len == 4 && head_is("PREV")) return EVT_PREV;
    if (trim_len == 9 && head_is("PLAYPAUSE")) return EVT_PLAYPAUSE;
    return EVT_NONE;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    if (dropping) begin
      // An overlong line swallows everything up to and including its newline.
      if (b == BYTE_NEWLINE) dropping = 1'b0;
    end else if (b == BYTE_NEWLINE) begin
      if (chunk_count < event_limit) begin
        expected_events.push_back(line_code());
        chunk_count++;
      end
      line_len = 0;
      text_len = 0;
      trim_len = 0;
      zero_in_line = 1'b0;
    end else if (line_len < LINE_CAPACITY - 1) begin
      if (line_len < HEAD_DEPTH) line_head[line_len] = b;
      line_len++;
      // The text ends at the first zero byte; trailing CRs are not counted.
      if (!zero_in_line) begin
        if (b == BYTE_ZERO) begin
          zero_in_line = 1'b1;
        end else begin
          text_len++;
          if (b != BYTE_CR) trim_len = text_len;
        end
      end
    end else begin
      dropping = 1'b1;
      line_len = 0;
      text_len = 0;
      trim_len = 0;
      zero_in_line = 1'b0;
    end
    // The byte counts toward the old chunk before the mark clears the count.
    if (last) chunk_count = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic logic chunk_mark();
    return ($urandom_range(0, 99) < chunk_pct);
  endfunction

  // Any byte but a newline, so that a line body never ends early.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == BYTE_NEWLINE) b = BYTE_CR;
    return b;
  endfunction

  function automatic string command_word(input int k);
    case (k)
      0:       return "STOP";
      1:       return "PING";
      2:       return "HELLO";
      3:       return "NEXT";
      4:       return "PREV";
      default: return "PLAYPAUSE";
    endcase
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) line_body.push_back(s[i]);
  endfunction

  // Sends one byte transaction. The task is entered at a rising edge, raises
  // valid with the payload and holds both until the edge at which ready is
  // seen high. At the end of a burst it may drop valid for a random gap;
  // inside a burst valid stays high so the next call only changes the payload
  // in the same time step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    data_valid <= 1'b1;
    data_byte  <= b;
    chunk_last <= last;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    predict_byte(b, last);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sends the prepared line body followed by its newline.
  task automatic send_body();
    foreach (line_body[i]) send_byte(line_body[i], chunk_mark());
    send_byte(BYTE_NEWLINE, chunk_mark());
  endtask

  task automatic send_line(input string s, input int crs);
    line_body.delete();
    append_text(s);
    repeat (crs) line_body.push_back(BYTE_CR);
    send_body();
  endtask

  // Waits until every expected event has come out and the record queue has
  // had time to drain the chunk marks and dropped lines behind it.
  task automatic wait_idle();
    data_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the events-per-chunk limit; the block must be idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    event_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // Builds one random line body. Most lines are commands with random
  // decoration (suffixes, trailing CRs, a zero byte and junk after it); the
  // rest are near misses, garbage and a rare overlong line.
  task automatic build_random_line(output line_kind_t kind);
    int pick;
    int pos;
    line_body.delete();
    pick = $urandom_range(0, 199);
    if (pick < 2) kind = LINE_OVERLONG;
    else if (pick < 110) kind = LINE_COMMAND;
    else if (pick < 150) kind = LINE_NEAR_MISS;
    else kind = LINE_GARBAGE;
    case (kind)
      LINE_COMMAND: begin
        append_text(command_word($urandom_range(0, 5)));
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 6)) line_body.push_back(body_byte());
        end
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) line_body.push_back(BYTE_CR);
        end
        if ($urandom_range(0, 4) == 0) begin
          line_body.push_back(BYTE_ZERO);
          repeat ($urandom_range(0, 4)) line_body.push_back(body_byte());
        end
      end
      LINE_NEAR_MISS: begin
        append_text(command_word($urandom_range(0, 5)));
        pos = $urandom_range(0, line_body.size() - 1);
        case ($urandom_range(0, 3))
          0:       line_body[pos] = body_byte();
          1:       void'(line_body.pop_back());
          2:       line_body.insert(pos, BYTE_CR);
          default: line_body[0] = line_body[0] | 8'h20;
        endcase
      end
      LINE_GARBAGE: begin
        repeat ($urandom_range(0, 12)) begin
          pick = $urandom_range(0, 23);
          if (pick < 4) line_body.push_back(BYTE_CR);
          else if (pick < 7) line_body.push_back(BYTE_ZERO);
          else line_body.push_back(body_byte());
        end
      end
      default: begin
        repeat ($urandom_range(LINE_CAPACITY - 4, LINE_CAPACITY + 8)) begin
          line_body.push_back(body_byte());
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Every event code at least once, CR trimming, the cut at a zero byte, the
  // byte extremes, an empty line and a chunk mark, at the reset limit.
  task automatic test_commands();
    chunk_pct = 0;
    send_line("STOP", 0);
    send_line("PING", 0);
    send_line("HELLO", 0);
    send_byte("N", 1'b0);
    send_byte("E", 1'b0);
    send_byte("X", 1'b0);
    send_byte("T", 1'b0);
    send_byte(BYTE_CR, 1'b0);
    send_byte(BYTE_ZERO, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(BYTE_NEWLINE, 1'b0);
    send_line("PREV", 0);
    send_line("PLAYPAUSE", 0);
    send_byte(BYTE_NEWLINE, 1'b1);
  endtask

  // Lines at the capacity boundary: the longest kept line, one of LINE_CAPACITY+3
  // bytes (dropped whole, its newline emits nothing), and recovery afterwards.
  task automatic test_line_length();
    chunk_pct = 0;
    line_body.delete();
    append_text("STOP");
    repeat (LINE_CAPACITY - 5) line_body.push_back(BYTE_ZERO);
    send_body();
    line_body.delete();
    append_text("STOP");
    repeat (LINE_CAPACITY - 4) line_body.push_back(BYTE_ZERO);
    repeat (3) line_body.push_back(body_byte());
    send_body();
    line_body.delete();
    append_text("HELLO");
    repeat (LINE_CAPACITY - 8) line_body.push_back(body_byte());
    repeat (2) line_body.push_back(BYTE_CR);
    send_body();
    send_line("PING", 1);
  endtask

  // The receiver holds off for a long stretch while the sender offers short
  // lines back to back, so the record queue fills and data_ready drops.
  task automatic test_backpressure();
    chunk_pct = 0;
    no_gaps = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (40) send_line(command_word($urandom_range(0, 5)), 0);
    no_gaps = 1'b0;
  endtask

  // Small limits, zero among them, with frequent chunk marks so that lines
  // both exceed and fall under the limit.
  task automatic test_event_limit();
    line_kind_t kind;
    for (int lim = 0; lim <= 3; lim++) begin
      wait_idle();
      write_limit(lim[LIMIT_W-1:0]);
      chunk_pct = 4;
      repeat (6) begin
        build_random_line(kind);
        send_body();
      end
    end
  endtask

  // The bulk of the run: random lines under four limit settings, ending at
  // the largest limit, until the whole run has sent about TOTAL_ITEMS bytes.
  task automatic test_random_traffic();
    int start;
    line_kind_t kind;
    logic [LIMIT_W-1:0] lim;
    start = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      if (phase == 1) lim = LIMIT_W'($urandom_range(1, 6));
      else if (phase == 2) lim = LIMIT_W'($urandom_range(0, 65535));
      else lim = LIMIT_RESET;
      write_limit(lim);
      chunk_pct = $urandom_range(1, 12);
      while (items_sent < start + (phase + 1) * (TOTAL_ITEMS - start) / 4) begin
        build_random_line(kind);
        send_body();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Event receiver. It picks a stall pattern for a random stretch of cycles,
  // and honors a long hold-off when a test asks for one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      event_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS:   event_ready <= 1'b1;
        READY_COIN:     event_ready <= 1'($urandom_range(0, 1));
        READY_MOSTLY:   event_ready <= ($urandom_range(0, 7) != 0);
        default:        event_ready <= ((cycle_count % 8) >= 3);
      endcase
    end
  end

  // Every event transaction is matched against the oldest expected code.
  always @(posedge clk) begin
    if (!rst && event_valid && event_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("event code %0d with no event expected", event_code));
      end else begin
        want_code = expected_events.pop_front();
        if (event_code !== want_code) begin
          report_mismatch($sformatf("event code %0d, expected %0d", event_code, want_code));
        end
      end
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_commands();
    test_line_length();
    test_backpressure();
    test_event_limit();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cmdc_pkg.sv
rtl/cmdc_front.sv
rtl/cmdc_fifo.sv
rtl/cmdc_back.sv
rtl/command_line_classifier_top.sv
tb/sv/tb_command_line_classifier_top.sv
